// ===== design/bffa_pkg.sv =====
// Shared types, constants and controller/datapath command and status structs
package bffa_pkg;

  localparam int unsigned CELL_COUNT_DEF    = 512;
  localparam int unsigned CELL_BYTES        = 128;
  localparam int unsigned CELL_SHIFT        = 7;
  localparam int unsigned SMALL_LIMIT_BYTES = 49152;
  localparam int unsigned RESERVED_LOW      = 2;
  localparam int unsigned WORD_BITS         = 8;
  localparam int unsigned WORD_SHIFT        = 3;
  localparam int unsigned CELLS_W           = 10;
  localparam int unsigned START_W           = 9;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_RUN    = 2'd1;
  localparam status_t ST_ZERO      = 2'd2;
  localparam status_t ST_UNHANDLED = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] size_bytes;
    logic [15:0] page_offset;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] block_offset;
    logic [8:0]  free_cells;
  } result_t;

  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_NEXT  = 2'd1,
    RD_LO    = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    scan;
    logic    set_free;
    logic    set_alloc;
    logic    write;
    logic    finish;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic kind_free;
    logic zero;
    logic over_limit;
    logic low_offs;
    logic short_cnt;
    logic free_skip;
    logic hit;
    logic last_word;
    logic at_hi_word;
  } stat_t;

endpackage

// ===== design/bffa_ctrl.sv =====
// Sequencing state machine for check, scan and mark of one item
module bffa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bffa_pkg::stat_t  stat_i,
  output bffa_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_FOUND   = 6'b001000,
    S_MARK_RD = 6'b010000,
    S_MARK    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = bffa_pkg::ST_ZERO;
          state_d      = S_IDLE;
        end else if (stat_i.kind_free) begin
          if (stat_i.low_offs) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = bffa_pkg::ST_UNHANDLED;
            state_d      = S_IDLE;
          end else if (stat_i.free_skip) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = bffa_pkg::ST_OK;
            state_d      = S_IDLE;
          end else begin
            cmd_o.set_free = 1'b1;
            state_d        = S_MARK_RD;
          end
        end else if (stat_i.over_limit) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = bffa_pkg::ST_UNHANDLED;
          state_d      = S_IDLE;
        end else if (stat_i.short_cnt) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = bffa_pkg::ST_NO_RUN;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = bffa_pkg::RD_FIRST;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          state_d = S_FOUND;
        end else if (stat_i.last_word) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = bffa_pkg::ST_NO_RUN;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bffa_pkg::RD_NEXT;
        end
      end
      S_FOUND: begin
        cmd_o.set_alloc = 1'b1;
        state_d         = S_MARK_RD;
      end
      S_MARK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bffa_pkg::RD_LO;
        state_d      = S_MARK;
      end
      S_MARK: begin
        cmd_o.write = 1'b1;
        if (stat_i.at_hi_word) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = bffa_pkg::ST_OK;
          state_d      = S_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bffa_pkg::RD_NEXT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== design/bffa_dp.sv =====
// Datapath: item registers, bitmap word store, run scan, mark logic and free count
module bffa_dp #(
  parameter int unsigned CELL_COUNT = bffa_pkg::CELL_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bffa_pkg::item_t   item_i,
  input  bffa_pkg::cmd_t    cmd_i,
  output bffa_pkg::stat_t   stat_o,
  output bffa_pkg::result_t result_o
);

  localparam int unsigned WB     = bffa_pkg::WORD_BITS;
  localparam int unsigned WS     = bffa_pkg::WORD_SHIFT;
  localparam int unsigned CSH    = bffa_pkg::CELL_SHIFT;
  localparam int unsigned CLW    = bffa_pkg::CELLS_W;
  localparam int unsigned STW    = bffa_pkg::START_W;
  localparam int unsigned CW     = $clog2(CELL_COUNT);
  localparam int unsigned AW     = CW - WS;
  localparam int unsigned NW     = (CELL_COUNT + WB - 1) / WB;
  localparam int unsigned EXT_W  = ((CW > CLW) ? CW : CLW) + 1;
  localparam int unsigned SCAN_LIMIT = CELL_COUNT - 2;

  // item registers
  logic            kind_q, zero_q, large_q, low_q;
  logic [CLW-1:0]  cells_q;
  logic [STW-1:0]  fstart_q;
  logic [16:0]     cells_sum;
  logic [15:0]     offs_rel;

  // allocator state
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   lo_q, hi_q;
  logic [CLW-1:0]  run_q;

  // bitmap store
  logic [WB-1:0]   map_q [NW];
  logic [NW-1:0]   valid_q;
  logic [WB-1:0]   rd_data_q;
  logic            rd_valid_q;
  logic [AW-1:0]   rd_addr_q, rd_addr_d;

  logic [CW-1:0]   bit_idx [WB];
  logic [WB-1:0]   rst_word, eff_word, mask, wr_data;

  logic [CLW-1:0]  run_v;
  logic            hit_v;
  logic [WS-1:0]   hit_b;

  logic [EXT_W-1:0] count_ext, cells_ext, fstart_ext, free_end, hi_free;
  logic [EXT_W-1:0] alloc_lo, sum_ext, new_count;
  logic [EXT_W-1:0] lo_plus;
  logic [EXT_W+CSH-1:0] off_full;
  logic             fin_ok;

  bffa_pkg::result_t res_q;

  assign cells_sum = {1'b0, item_i.size_bytes} + 17'(bffa_pkg::CELL_BYTES - 1);
  assign offs_rel  = item_i.page_offset - 16'(bffa_pkg::RESERVED_LOW * bffa_pkg::CELL_BYTES);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= item_i.kind;
      zero_q   <= (item_i.size_bytes == '0);
      large_q  <= ({1'b0, item_i.size_bytes} > 17'(bffa_pkg::SMALL_LIMIT_BYTES));
      low_q    <= (item_i.page_offset <
                   16'(bffa_pkg::RESERVED_LOW * bffa_pkg::CELL_BYTES));
      cells_q  <= CLW'(cells_sum >> CSH);
      fstart_q <= STW'(offs_rel >> CSH);
    end
  end

  assign count_ext  = EXT_W'(count_q);
  assign cells_ext  = EXT_W'(cells_q);
  assign fstart_ext = EXT_W'(fstart_q);
  assign free_end   = fstart_ext + cells_ext - EXT_W'(1);
  assign hi_free    = (free_end > EXT_W'(CELL_COUNT - 1)) ? EXT_W'(CELL_COUNT - 1) : free_end;
  assign alloc_lo   = EXT_W'(hi_q) + EXT_W'(1) - cells_ext;

  // cell index, reset pattern and mark mask of each bit in the word now held
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      bit_idx[b]  = {rd_addr_q, WS'(b)};
      rst_word[b] = (bit_idx[b] < CW'(bffa_pkg::RESERVED_LOW)) ||
                    (bit_idx[b] == CW'(CELL_COUNT - 2)) ||
                    (bit_idx[b] == CW'(CELL_COUNT - 1));
      mask[b]     = (bit_idx[b] >= lo_q) && (bit_idx[b] <= hi_q);
    end
  end

  assign eff_word = rd_valid_q ? rd_data_q : rst_word;
  assign wr_data  = (kind_q == bffa_pkg::KIND_ALLOC) ? (eff_word | mask) : (eff_word & ~mask);

  // first-fit run counting over one word
  always_comb begin
    run_v = run_q;
    hit_v = 1'b0;
    hit_b = '0;
    for (int b = 0; b < WB; b++) begin
      if (!hit_v) begin
        if (eff_word[b] || (bit_idx[b] >= CW'(SCAN_LIMIT))) begin
          run_v = '0;
        end else begin
          run_v = run_v + CLW'(1);
          if (run_v == cells_q) begin
            hit_v = 1'b1;
            hit_b = WS'(b);
          end
        end
      end
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      bffa_pkg::RD_FIRST: rd_addr_d = '0;
      bffa_pkg::RD_NEXT:  rd_addr_d = rd_addr_q + AW'(1);
      bffa_pkg::RD_LO:    rd_addr_d = lo_q[CW-1:WS];
      default:            rd_addr_d = rd_addr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      map_q[rd_addr_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= map_q[rd_addr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (cmd_i.write) begin
        valid_q[rd_addr_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_addr_q  <= rd_addr_d;
        rd_valid_q <= valid_q[rd_addr_d];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      run_q <= '0;
    end else if (cmd_i.scan) begin
      run_q <= run_v;
    end
    if (cmd_i.set_free) begin
      lo_q <= CW'(fstart_ext);
      hi_q <= CW'(hi_free);
    end else if (cmd_i.set_alloc) begin
      lo_q <= CW'(alloc_lo);
    end else if (cmd_i.scan && hit_v) begin
      hi_q <= {rd_addr_q, hit_b};
    end
  end

  // count update and result
  assign sum_ext = count_ext + cells_ext;
  assign fin_ok  = (cmd_i.status == bffa_pkg::ST_OK);

  always_comb begin
    if (!fin_ok) begin
      new_count = count_ext;
    end else if (kind_q == bffa_pkg::KIND_ALLOC) begin
      new_count = count_ext - cells_ext;
    end else if (sum_ext > EXT_W'(SCAN_LIMIT)) begin
      new_count = EXT_W'(SCAN_LIMIT);
    end else begin
      new_count = sum_ext;
    end
  end

  assign lo_plus  = EXT_W'(lo_q) + EXT_W'(bffa_pkg::RESERVED_LOW);
  assign off_full = {lo_plus, {CSH{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(SCAN_LIMIT);
    end else if (cmd_i.finish) begin
      count_q <= CW'(new_count);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.status       <= cmd_i.status;
      res_q.block_offset <= (fin_ok && (kind_q == bffa_pkg::KIND_ALLOC)) ?
                            off_full[15:0] : 16'd0;
      res_q.free_cells   <= new_count[8:0];
    end
  end

  assign stat_o.kind_free  = (kind_q == bffa_pkg::KIND_FREE);
  assign stat_o.zero       = zero_q;
  assign stat_o.over_limit = large_q;
  assign stat_o.low_offs   = low_q;
  assign stat_o.short_cnt  = (count_ext < cells_ext);
  assign stat_o.free_skip  = (fstart_ext >= EXT_W'(CELL_COUNT));
  assign stat_o.hit        = hit_v;
  assign stat_o.last_word  = (rd_addr_q == AW'(NW - 1));
  assign stat_o.at_hi_word = (rd_addr_q == hi_q[CW-1:WS]);

  assign result_o = res_q;

endmodule

// ===== design/bitmap_first_fit_cell_allocator.sv =====
// Top level of the bitmap first-fit cell allocator: controller, datapath, checks
//
//   port      dir  type      role
//   start     in   logic     item request, taken when busy is low
//   item_i    in   item_t    kind, size_bytes, page_offset
//   busy      out  logic     item in progress
//   done_o    out  logic     result strobe, one cycle
//   result_o  out  result_t  status, block_offset, free_cells
//
// The bitmap sits in a word store of 8 cells per word, one word read per cycle.
// Zero size, large, bad offset or short count: the item ends in the check state.
// Alloc: check, scan word by word to a hit, then read back and mark the run's words.
// Free: check, read back, clear. Reset gives the initial map at once via word valid bits.
// The result strobe cannot be stalled; a new item may start in the strobe cycle.
module bitmap_first_fit_cell_allocator #(
  parameter int unsigned CELL_COUNT = bffa_pkg::CELL_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  bffa_pkg::item_t   item_i,
  output logic              busy,
  output logic              done_o,
  output bffa_pkg::result_t result_o
);

  bffa_pkg::cmd_t  cmd;
  bffa_pkg::stat_t stat;

  bffa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  bffa_dp #(
    .CELL_COUNT(CELL_COUNT)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .result_o(result_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_busy_ends_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("item ended without a result");

  a_offset_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != bffa_pkg::ST_OK)) |-> (result_o.block_offset == 16'd0))
    else $error("non-zero offset on a failed item");

endmodule

// ===== tb/bitmap_first_fit_cell_allocator_tb.sv =====
// Self-checking testbench for the bitmap first-fit cell allocator
module bitmap_first_fit_cell_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  localparam int unsigned SCAN_CELLS   = CELL_COUNT_DEF - 2;
  localparam int unsigned AREA_BASE    = RESERVED_LOW * CELL_BYTES;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          SETTLE_TICKS = 200;
  localparam int          RANDOM_ITEMS = 926;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  bit          cell_taken [CELL_COUNT_DEF];
  int unsigned spare_cells;
  result_t     expected_results [$];
  dir_row_t    dir_rows [$];
  int unsigned live_offs [$];
  int unsigned live_size [$];

  int cycle_count;
  int mismatches;
  int results_checked;
  int items_sent;
  int n_placed, n_refused, n_freed, n_rejected;

  bitmap_first_fit_cell_allocator uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d offs=%0d free=%0d", result_o.status,
                   result_o.block_offset, result_o.free_cells);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result_o.status !== want.status || result_o.block_offset !== want.block_offset
            || result_o.free_cells !== want.free_cells) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want st=%0d offs=%0d free=%0d, got st=%0d offs=%0d free=%0d",
                     want.status, want.block_offset, want.free_cells, result_o.status,
                     result_o.block_offset, result_o.free_cells);
        end
      end
    end
  end

  function automatic void clear_map();
    for (int i = 0; i < CELL_COUNT_DEF; i++) cell_taken[i] = 1'b0;
    cell_taken[0] = 1'b1;
    cell_taken[1] = 1'b1;
    cell_taken[CELL_COUNT_DEF-2] = 1'b1;
    cell_taken[CELL_COUNT_DEF-1] = 1'b1;
    spare_cells = SCAN_CELLS;
  endfunction

  // Applies one item to the local copy of the bitmap and count
  function automatic result_t apply_item(item_t it);
    result_t     r;
    int unsigned cells, first, run, idx;
    bit          found;
    r = '0;
    r.status = ST_OK;
    cells = (int'(it.size_bytes) + CELL_BYTES - 1) / CELL_BYTES;
    if (it.size_bytes == 0) begin
      r.status = ST_ZERO;
    end else if (it.kind == KIND_ALLOC) begin
      if (it.size_bytes > SMALL_LIMIT_BYTES) begin
        r.status = ST_UNHANDLED;
      end else begin
        found = 1'b0;
        run = 0;
        first = 0;
        if (spare_cells >= cells) begin
          for (idx = 0; idx < SCAN_CELLS && !found; idx++) begin
            if (cell_taken[idx]) begin
              run = 0;
            end else begin
              run++;
              if (run == cells) begin
                found = 1'b1;
                first = idx + 1 - cells;
              end
            end
          end
        end
        if (!found) begin
          r.status = ST_NO_RUN;
        end else begin
          for (idx = first; idx < first + cells; idx++) cell_taken[idx] = 1'b1;
          spare_cells -= cells;
          r.block_offset = 16'(CELL_BYTES * (first + RESERVED_LOW));
        end
      end
    end else if (it.page_offset < AREA_BASE) begin
      r.status = ST_UNHANDLED;
    end else begin
      first = (int'(it.page_offset) - AREA_BASE) / CELL_BYTES;
      for (idx = first; idx < first + cells; idx++)
        if (idx < CELL_COUNT_DEF) cell_taken[idx] = 1'b0;
      spare_cells += cells;
      if (spare_cells > SCAN_CELLS) spare_cells = SCAN_CELLS;
    end
    r.free_cells = 9'(spare_cells);
    return r;
  endfunction

  function automatic void add_row(logic kind, int unsigned size, int unsigned offs, bit typed,
                                  status_t st, int unsigned boffs, int unsigned fc);
    dir_row_t row;
    row.it.kind        = kind;
    row.it.size_bytes  = 16'(size);
    row.it.page_offset = 16'(offs);
    row.typed          = typed;
    row.want.status       = st;
    row.want.block_offset = 16'(boffs);
    row.want.free_cells   = 9'(fc);
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t pred;
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = apply_item(it);
    expected_results.push_back(typed ? want : pred);
    items_sent++;
    case (pred.status)
      ST_OK:     if (it.kind == KIND_ALLOC) n_placed++; else n_freed++;
      ST_NO_RUN: n_refused++;
      default:   n_rejected++;
    endcase
    if (it.kind == KIND_ALLOC && pred.status == ST_OK) begin
      live_offs.push_back(pred.block_offset);
      live_size.push_back(it.size_bytes);
    end
  endtask

  task automatic idle_sender(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    item_t       it;
    result_t     none;
    int unsigned idle_pct, pick, r;
    none = '0;
    clear_map();
    // directed: rejects, first allocations after reset, wrap and saturation,
    // count large enough but no run, exhaustion
    add_row(KIND_ALLOC, 0,     0,     1, ST_ZERO,      0,     510);
    add_row(KIND_FREE,  0,     0,     1, ST_ZERO,      0,     510);
    add_row(KIND_ALLOC, 49153, 0,     1, ST_UNHANDLED, 0,     510);
    add_row(KIND_ALLOC, 65535, 65535, 1, ST_UNHANDLED, 0,     510);
    add_row(KIND_FREE,  128,   0,     1, ST_UNHANDLED, 0,     510);
    add_row(KIND_FREE,  1,     255,   1, ST_UNHANDLED, 0,     510);
    add_row(KIND_ALLOC, 1,     0,     1, ST_OK,        512,   509);
    add_row(KIND_ALLOC, 128,   0,     1, ST_OK,        640,   508);
    add_row(KIND_ALLOC, 129,   0,     1, ST_OK,        768,   506);
    add_row(KIND_FREE,  128,   640,   0, ST_OK,        0,     0);
    add_row(KIND_ALLOC, 1,     0,     0, ST_OK,        0,     0);
    add_row(KIND_FREE,  200,   1000,  0, ST_OK,        0,     0);
    add_row(KIND_ALLOC, 49152, 0,     0, ST_OK,        0,     0);
    add_row(KIND_ALLOC, 49152, 0,     0, ST_OK,        0,     0);
    add_row(KIND_FREE,  65535, 65535, 1, ST_OK,        0,     510);
    add_row(KIND_FREE,  65535, 256,   1, ST_OK,        0,     510);
    add_row(KIND_ALLOC, 49152, 0,     1, ST_OK,        256,   126);
    add_row(KIND_FREE,  1,     1536,  1, ST_OK,        0,     127);
    add_row(KIND_ALLOC, 16256, 0,     1, ST_NO_RUN,    0,     127);
    add_row(KIND_ALLOC, 16257, 0,     1, ST_NO_RUN,    0,     127);
    add_row(KIND_ALLOC, 16128, 0,     1, ST_OK,        49408, 1);
    add_row(KIND_ALLOC, 1,     0,     1, ST_OK,        1536,  0);
    add_row(KIND_ALLOC, 1,     0,     1, ST_NO_RUN,    0,     0);
    add_row(KIND_FREE,  65535, 256,   1, ST_OK,        0,     510);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      idle_sender(15);
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end
    live_offs.delete();
    live_size.delete();
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 76 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        r = $urandom_range(99);
        it.kind        = KIND_ALLOC;
        it.page_offset = 16'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 70)      it.size_bytes = 16'($urandom_range(1024, 1));
        else if (pick < 90) it.size_bytes = 16'($urandom_range(8192, 1025));
        else if (pick < 97) it.size_bytes = 16'($urandom_range(49152, 8193));
        else if (pick < 98) it.size_bytes = 16'd0;
        else                it.size_bytes = 16'($urandom_range(65535, 49153));
        if (r >= 45 && r < 85 && live_offs.size() != 0) begin
          pick = $urandom_range(live_offs.size() - 1);
          it.kind        = KIND_FREE;
          it.page_offset = 16'(live_offs[pick]);
          it.size_bytes  = 16'(live_size[pick]);
          live_offs.delete(pick);
          live_size.delete(pick);
          if ($urandom_range(9) == 0) begin
            it.page_offset = it.page_offset + 16'($urandom_range(127));
            it.size_bytes  = 16'($urandom_range(4096, 1));
          end
        end else if (r >= 85) begin
          it.kind       = logic'($urandom_range(1));
          it.size_bytes = 16'($urandom_range(65535));
        end
        idle_sender(idle_pct);
        send_item(it, 1'b0, none);
      end
      // hold off until everything in flight has been returned
      drain();
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    $display("%0d items (%0d directed), %0d results checked, %0d mismatches",
             items_sent, dir_rows.size(), results_checked, mismatches);
    $display("placed %0d, refused %0d, freed %0d, rejected %0d; three idling phases",
             n_placed, n_refused, n_freed, n_rejected);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
